// File: hw/rtl/multiturn_encoder_tracker_top_macros.svh
// ---------------------------------------------------------------------------
// Multi-turn encoder tracker: assertion macros
// Shared concurrent assertion forms for the tracker modules.
// ---------------------------------------------------------------------------
`ifndef MULTITURN_ENCODER_TRACKER_TOP_MACROS_SVH
`define MULTITURN_ENCODER_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTE_CHECK(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTE_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mte_pkg.sv
// ---------------------------------------------------------------------------
// Multi-turn encoder tracker package
// Types, register indices, microcode encodings and the control program.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mte_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PC_W       = 6;
    localparam int REM_CNT_W  = 5;

    localparam logic [REM_CNT_W-1:0] REM_STEPS = 5'd16;

    // pi / 30 as unsigned Q0.32.
    localparam logic [31:0] PI_OVER_30_Q32 = 32'd449767923;

    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_TURN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIANS_PER_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_REDUCTION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_ZERO       = 3'd6;

    typedef struct packed {
        logic [15:0]        angle_raw;
        logic signed [15:0] speed_raw;
        logic [7:0]         temperature_raw;
    } t_in;

    typedef struct packed {
        logic signed [15:0] wrapped_count;
        logic signed [15:0] count_delta;
        logic signed [31:0] turn_count;
        logic signed [31:0] rotor_angle;
        logic signed [31:0] rotor_polar_angle;
        logic signed [31:0] rotor_velocity;
        logic signed [31:0] output_angle;
        logic signed [31:0] output_velocity;
        logic signed [31:0] linear_displacement;
        logic signed [31:0] relative_displacement;
        logic signed [31:0] linear_velocity;
        logic [7:0]         temperature;
    } t_out;

    typedef struct packed {
        logic [15:0]        counts_per_turn;
        logic [15:0]        zero_offset;
        logic               reverse;
        logic [31:0]        radians_per_count;
        logic [31:0]        inverse_reduction;
        logic [31:0]        wheel_radius;
        logic signed [31:0] linear_zero;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        counts_per_turn:   16'd8192,
        zero_offset:       16'd0,
        reverse:           1'b0,
        radians_per_count: 32'd3294199,
        inverse_reduction: 32'd65536,
        wheel_radius:      32'd65536,
        linear_zero:       32'sd0
    };

    // Datapath operations.
    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_TAKE   = 4'd1;
    localparam logic [3:0] OP_LOAD   = 4'd2;
    localparam logic [3:0] OP_WRAP   = 4'd3;
    localparam logic [3:0] OP_UNWRAP = 4'd4;
    localparam logic [3:0] OP_TMUL   = 4'd5;
    localparam logic [3:0] OP_TOTAL  = 4'd6;
    localparam logic [3:0] OP_MAG    = 4'd7;
    localparam logic [3:0] OP_MHI    = 4'd8;
    localparam logic [3:0] OP_MLO    = 4'd9;
    localparam logic [3:0] OP_FIN    = 4'd10;
    localparam logic [3:0] OP_REL    = 4'd11;
    localparam logic [3:0] OP_EMIT   = 4'd12;

    // Scaling sources.
    localparam logic [2:0] SRC_TOTAL = 3'd0;
    localparam logic [2:0] SRC_POL   = 3'd1;
    localparam logic [2:0] SRC_RPM   = 3'd2;
    localparam logic [2:0] SRC_ANG   = 3'd3;
    localparam logic [2:0] SRC_VEL   = 3'd4;
    localparam logic [2:0] SRC_OANG  = 3'd5;
    localparam logic [2:0] SRC_OVEL  = 3'd6;

    // Scaling factors.
    localparam logic [1:0] K_RPC  = 2'd0;
    localparam logic [1:0] K_PI30 = 2'd1;
    localparam logic [1:0] K_INVR = 2'd2;
    localparam logic [1:0] K_RAD  = 2'd3;

    // Scaling destinations.
    localparam logic [2:0] DST_ANG  = 3'd0;
    localparam logic [2:0] DST_POL  = 3'd1;
    localparam logic [2:0] DST_VEL  = 3'd2;
    localparam logic [2:0] DST_OANG = 3'd3;
    localparam logic [2:0] DST_OVEL = 3'd4;
    localparam logic [2:0] DST_DISP = 3'd5;
    localparam logic [2:0] DST_LVEL = 3'd6;

    // Conditions on which a step holds.
    localparam logic [1:0] HOLD_NONE = 2'd0;
    localparam logic [1:0] HOLD_IN   = 2'd1;
    localparam logic [1:0] HOLD_REM  = 2'd2;
    localparam logic [1:0] HOLD_OUT  = 2'd3;

    // Program addresses.
    localparam logic [PC_W-1:0] PC_IDLE   = 6'd0;
    localparam logic [PC_W-1:0] PC_LOAD   = 6'd1;
    localparam logic [PC_W-1:0] PC_DIV    = 6'd2;
    localparam logic [PC_W-1:0] PC_WRAP   = 6'd3;
    localparam logic [PC_W-1:0] PC_UNWRAP = 6'd4;
    localparam logic [PC_W-1:0] PC_TMUL   = 6'd5;
    localparam logic [PC_W-1:0] PC_TOTAL  = 6'd6;
    localparam logic [PC_W-1:0] PC_SCALE0 = 6'd7;
    localparam logic [PC_W-1:0] PC_REL    = 6'd35;
    localparam logic [PC_W-1:0] PC_EMIT   = 6'd36;

    typedef struct packed {
        logic [3:0]      op;
        logic [2:0]      src;
        logic [1:0]      ksel;
        logic [2:0]      dst;
        logic [1:0]      hold_on;
        logic            jump;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_uword uw;
        logic   go;
    } t_ctrl;

    typedef struct packed {
        logic rem_busy;
        logic out_busy;
    } t_status;

    // Control store. Each scaling takes four steps: magnitude, high partial
    // product, low partial product, then sum, shift and saturate.
    function automatic t_uword f_ucode(input logic [PC_W-1:0] pc);
        t_uword          w;
        logic [PC_W-1:0] rel_pc;
        logic [2:0]      sc;
        w         = '0;
        w.op      = OP_NOP;
        w.hold_on = HOLD_NONE;
        w.jump    = 1'b0;
        w.target  = PC_IDLE;
        rel_pc    = pc - PC_SCALE0;
        sc        = rel_pc[4:2];
        if (pc >= PC_SCALE0 && pc < PC_REL) begin
            case (rel_pc[1:0])
                2'd0:    w.op = OP_MAG;
                2'd1:    w.op = OP_MHI;
                2'd2:    w.op = OP_MLO;
                default: w.op = OP_FIN;
            endcase
            case (sc)
                3'd0: begin
                    w.src = SRC_TOTAL; w.ksel = K_RPC;  w.dst = DST_ANG;
                end
                3'd1: begin
                    w.src = SRC_POL;   w.ksel = K_RPC;  w.dst = DST_POL;
                end
                3'd2: begin
                    w.src = SRC_RPM;   w.ksel = K_PI30; w.dst = DST_VEL;
                end
                3'd3: begin
                    w.src = SRC_ANG;   w.ksel = K_INVR; w.dst = DST_OANG;
                end
                3'd4: begin
                    w.src = SRC_VEL;   w.ksel = K_INVR; w.dst = DST_OVEL;
                end
                3'd5: begin
                    w.src = SRC_OANG;  w.ksel = K_RAD;  w.dst = DST_DISP;
                end
                default: begin
                    w.src = SRC_OVEL;  w.ksel = K_RAD;  w.dst = DST_LVEL;
                end
            endcase
        end else begin
            case (pc)
                PC_IDLE: begin
                    w.op      = OP_TAKE;
                    w.hold_on = HOLD_IN;
                end
                PC_LOAD:   w.op = OP_LOAD;
                PC_DIV:    w.hold_on = HOLD_REM;
                PC_WRAP:   w.op = OP_WRAP;
                PC_UNWRAP: w.op = OP_UNWRAP;
                PC_TMUL:   w.op = OP_TMUL;
                PC_TOTAL:  w.op = OP_TOTAL;
                PC_REL:    w.op = OP_REL;
                PC_EMIT: begin
                    w.op      = OP_EMIT;
                    w.hold_on = HOLD_OUT;
                    w.jump    = 1'b1;
                    w.target  = PC_IDLE;
                end
                default: begin
                    w.jump   = 1'b1;
                    w.target = PC_IDLE;
                end
            endcase
        end
        return w;
    endfunction

endpackage

// File: hw/rtl/multiturn_encoder_tracker_top.sv
// ---------------------------------------------------------------------------
// Multi-turn encoder tracker
// Unwraps motor feedback reports into turn count, angles, velocities and
// linear displacement in saturating Q16.16.
// ---------------------------------------------------------------------------
// Usage:
//   A report is transferred on the input channel when i_in_valid is high
//   and o_in_stall is low; its result is transferred on the output channel
//   when o_out_valid is high and i_out_stall is low. One result follows
//   every report, in order.
//   A report is taken only when the sequencer is back at its idle step,
//   after the previous result is in the output register. The pace is set
//   by the remainder loop and by seven four-step scalings through the
//   single shared 24 by 32 bit multiplier, stepped by the microcode sequencer.
//   A result waiting in the output register does not stop the next report
//   being taken; if it is still stalled when the next result is ready, the
//   sequencer holds on its final step until the output register is free.
//   Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data;
//   the user must write it only while no report is in flight, which the
//   block itself does not enforce. Synchronous reset loads the default
//   configuration and clears the previous count, the turn counter and the output valid flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module multiturn_encoder_tracker_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  mte_pkg::t_in                       i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output mte_pkg::t_out                      o_out_data,
    input  logic                               i_cfg_we,
    input  logic [mte_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mte_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mte_pkg::*;

    t_cfg    r_cfg;
    t_ctrl   w_ctrl;
    t_status w_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COUNTS_PER_TURN:   r_cfg.counts_per_turn   <= i_cfg_data[15:0];
                REG_ZERO_OFFSET:       r_cfg.zero_offset       <= i_cfg_data[15:0];
                REG_REVERSE:           r_cfg.reverse           <= i_cfg_data[0];
                REG_RADIANS_PER_COUNT: r_cfg.radians_per_count <= i_cfg_data;
                REG_INVERSE_REDUCTION: r_cfg.inverse_reduction <= i_cfg_data;
                REG_WHEEL_RADIUS:      r_cfg.wheel_radius      <= i_cfg_data;
                REG_LINEAR_ZERO:       r_cfg.linear_zero       <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    mte_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (w_st),
        .o_ctrl     (w_ctrl),
        .o_in_stall (o_in_stall)
    );

    mte_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_cfg       (r_cfg),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_st        (w_st)
    );

endmodule

// File: hw/rtl/mte_rem.sv
// ---------------------------------------------------------------------------
// Multi-turn encoder tracker: remainder unit
// Restoring remainder of a 16-bit magnitude by the turn size, one bit a cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multiturn_encoder_tracker_top_macros.svh"

module mte_rem (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_busy,
    output logic [15:0] o_rem
);
    import mte_pkg::*;

    logic [REM_CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0]          r_rem, n_rem;
    logic [15:0]          r_dvd, n_dvd;
    logic [16:0]          w_trial;

    always_comb begin
        w_trial = {r_rem, r_dvd[15]};
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_cnt   = r_cnt;
        if (i_start) begin
            n_rem = '0;
            n_dvd = i_dividend;
            n_cnt = REM_STEPS;
        end else if (r_cnt != '0) begin
            if (w_trial >= {1'b0, i_divisor}) begin
                n_rem = 16'(w_trial - {1'b0, i_divisor});
            end else begin
                n_rem = w_trial[15:0];
            end
            n_dvd = {r_dvd[14:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_rem;

    `MTE_CHECK_NEXT(a_start_arms, i_clk, i_rst_n, i_start, r_cnt == REM_STEPS, "remainder unit did not arm")
    `MTE_CHECK(a_rem_below_divisor, i_clk, i_rst_n, r_cnt != '0, r_rem < i_divisor, "partial remainder not below divisor")

endmodule

// File: hw/rtl/mte_seq.sv
// ---------------------------------------------------------------------------
// Multi-turn encoder tracker: sequencer
// Step counter over the control store, with holds and jumps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multiturn_encoder_tracker_top_macros.svh"

module mte_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  mte_pkg::t_status i_st,
    output mte_pkg::t_ctrl   o_ctrl,
    output logic             o_in_stall
);
    import mte_pkg::*;

    logic [PC_W-1:0] r_pc, n_pc;
    t_uword          w_uw;
    logic            w_hold;

    always_comb begin
        w_uw = f_ucode(r_pc);
        case (w_uw.hold_on)
            HOLD_IN:  w_hold = !i_in_valid;
            HOLD_REM: w_hold = i_st.rem_busy;
            HOLD_OUT: w_hold = i_st.out_busy;
            default:  w_hold = 1'b0;
        endcase
        if (w_hold) begin
            n_pc = r_pc;
        end else if (w_uw.jump) begin
            n_pc = w_uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.uw  = w_uw;
    assign o_ctrl.go  = !w_hold;
    assign o_in_stall = (r_pc != PC_IDLE);

    `MTE_CHECK(a_pc_in_program, i_clk, i_rst_n, 1'b1, r_pc <= PC_EMIT, "step counter left the program")
    `MTE_CHECK_NEXT(a_emit_holds, i_clk, i_rst_n, (r_pc == PC_EMIT) && i_st.out_busy, r_pc == PC_EMIT, "result step advanced over a full output")

endmodule

// File: hw/rtl/mte_dpath.sv
// ---------------------------------------------------------------------------
// Multi-turn encoder tracker: datapath
// Recentring, unwrapping, turn count and saturating Q16.16 scaling through
// one shared 24 by 32 bit multiplier, plus the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multiturn_encoder_tracker_top_macros.svh"

module mte_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mte_pkg::t_ctrl   i_ctrl,
    input  mte_pkg::t_cfg    i_cfg,
    input  mte_pkg::t_in     i_in_data,
    output mte_pkg::t_out    o_out_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output mte_pkg::t_status o_st
);
    import mte_pkg::*;

    t_in                r_in;
    logic               r_xneg;
    logic signed [15:0] r_d;
    logic signed [15:0] r_delta;
    logic [15:0]        r_prev;
    logic signed [31:0] r_rev;
    logic [55:0]        r_prod;
    logic [79:0]        r_acc;
    logic signed [48:0] r_total;
    logic [47:0]        r_mag;
    logic               r_neg;
    logic signed [31:0] r_ang, r_pol, r_vel, r_oang, r_ovel, r_disp, r_lvel, r_rel;
    t_out               r_out;
    logic               r_out_valid;

    logic               w_go;
    logic [3:0]         w_op;
    logic [15:0]        w_cpt;
    logic [15:0]        w_half;
    logic [16:0]        w_x;
    logic [16:0]        w_xabs;
    logic               w_rem_busy;
    logic [15:0]        w_rem;
    logic [15:0]        w_d0;
    logic [16:0]        w_dw;
    logic signed [17:0] w_dl, w_h18, w_c18, w_delta;
    logic signed [31:0] w_rev_next;
    logic [31:0]        w_rev_abs;
    logic [23:0]        w_ma;
    logic [31:0]        w_mb;
    logic [55:0]        w_mp;
    logic [31:0]        w_k;
    logic signed [48:0] w_p49, w_d49, w_tot;
    logic signed [48:0] w_src, w_src_neg;
    logic               w_rotor;
    logic [79:0]        w_sum;
    logic [63:0]        w_q;
    logic [31:0]        w_sat;
    logic signed [32:0] w_rel33;
    logic signed [31:0] w_rel;
    t_out               w_out;

    assign w_go = i_ctrl.go;
    assign w_op = i_ctrl.uw.op;

    mte_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_go && (w_op == OP_LOAD)),
        .i_dividend (w_xabs[15:0]),
        .i_divisor  (w_cpt),
        .o_busy     (w_rem_busy),
        .o_rem      (w_rem)
    );

    always_comb begin
        w_cpt  = (i_cfg.counts_per_turn < 16'd2) ? 16'd2 : i_cfg.counts_per_turn;
        w_half = {1'b0, w_cpt[15:1]};
        w_x    = {1'b0, r_in.angle_raw} - {1'b0, i_cfg.zero_offset};
        w_xabs = w_x[16] ? (17'd0 - w_x) : w_x;

        w_d0 = (r_xneg && (w_rem != 16'd0)) ? (w_cpt - w_rem) : w_rem;
        w_dw = (w_d0 >= w_half) ? ({1'b0, w_d0} - {1'b0, w_cpt}) : {1'b0, w_d0};

        w_dl  = {{2{r_d[15]}}, r_d} - {{2{r_prev[15]}}, r_prev};
        w_h18 = $signed({2'b00, w_half});
        w_c18 = $signed({2'b00, w_cpt});
        if (w_dl < -w_h18) begin
            w_rev_next = r_rev + 32'sd1;
            w_delta    = w_dl + w_c18;
        end else if (w_dl > w_h18) begin
            w_rev_next = r_rev - 32'sd1;
            w_delta    = w_dl - w_c18;
        end else begin
            w_rev_next = r_rev;
            w_delta    = w_dl;
        end

        w_rev_abs = r_rev[31] ? (32'd0 - r_rev) : r_rev;

        case (i_ctrl.uw.ksel)
            K_RPC:   w_k = i_cfg.radians_per_count;
            K_PI30:  w_k = PI_OVER_30_Q32;
            K_INVR:  w_k = i_cfg.inverse_reduction;
            K_RAD:   w_k = i_cfg.wheel_radius;
            default: w_k = i_cfg.radians_per_count;
        endcase

        case (w_op)
            OP_TMUL: begin
                w_ma = {8'd0, w_cpt};
                w_mb = w_rev_abs;
            end
            OP_MHI: begin
                w_ma = r_mag[47:24];
                w_mb = w_k;
            end
            default: begin
                w_ma = r_mag[23:0];
                w_mb = w_k;
            end
        endcase
        w_mp = w_ma * w_mb;

        w_p49 = $signed({1'b0, r_prod[47:0]});
        w_d49 = {{33{r_d[15]}}, r_d};
        w_tot = (r_rev[31] ? -w_p49 : w_p49) + w_d49;

        case (i_ctrl.uw.src)
            SRC_TOTAL: w_src = r_total;
            SRC_POL:   w_src = w_d49;
            SRC_RPM:   w_src = {{33{r_in.speed_raw[15]}}, r_in.speed_raw};
            SRC_ANG:   w_src = {{17{r_ang[31]}}, r_ang};
            SRC_VEL:   w_src = {{17{r_vel[31]}}, r_vel};
            SRC_OANG:  w_src = {{17{r_oang[31]}}, r_oang};
            default:   w_src = {{17{r_ovel[31]}}, r_ovel};
        endcase
        w_src_neg = -w_src;
        w_rotor   = (i_ctrl.uw.src == SRC_TOTAL) || (i_ctrl.uw.src == SRC_POL)
                 || (i_ctrl.uw.src == SRC_RPM);

        w_sum = r_acc + {24'd0, r_prod};
        w_q   = w_sum[79:16];
        if (r_neg) begin
            if ((|w_q[63:32]) || (w_q[31] && (|w_q[30:0]))) begin
                w_sat = 32'h8000_0000;
            end else begin
                w_sat = 32'd0 - w_q[31:0];
            end
        end else begin
            w_sat = (|w_q[63:31]) ? 32'h7FFF_FFFF : w_q[31:0];
        end

        w_rel33 = {r_disp[31], r_disp} - {i_cfg.linear_zero[31], i_cfg.linear_zero};
        if (w_rel33[32] != w_rel33[31]) begin
            w_rel = w_rel33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_rel = w_rel33[31:0];
        end

        w_out.wrapped_count         = r_d;
        w_out.count_delta           = r_delta;
        w_out.turn_count            = r_rev;
        w_out.rotor_angle           = r_ang;
        w_out.rotor_polar_angle     = r_pol;
        w_out.rotor_velocity        = r_vel;
        w_out.output_angle          = r_oang;
        w_out.output_velocity       = r_ovel;
        w_out.linear_displacement   = r_disp;
        w_out.relative_displacement = r_rel;
        w_out.linear_velocity       = r_lvel;
        w_out.temperature           = r_in.temperature_raw;
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            case (w_op)
                OP_TAKE:   r_in <= i_in_data;
                OP_LOAD:   r_xneg <= w_x[16];
                OP_WRAP:   r_d <= w_dw[15:0];
                OP_UNWRAP: r_delta <= w_delta[15:0];
                OP_TMUL:   r_prod <= w_mp;
                OP_TOTAL:  r_total <= w_tot;
                OP_MAG: begin
                    r_neg <= w_src[48] ^ (i_cfg.reverse & w_rotor);
                    r_mag <= w_src[48] ? w_src_neg[47:0] : w_src[47:0];
                end
                OP_MHI:    r_prod <= w_mp;
                OP_MLO: begin
                    r_acc  <= {r_prod, 24'd0};
                    r_prod <= w_mp;
                end
                OP_FIN: begin
                    case (i_ctrl.uw.dst)
                        DST_ANG:  r_ang  <= w_sat;
                        DST_POL:  r_pol  <= w_sat;
                        DST_VEL:  r_vel  <= w_sat;
                        DST_OANG: r_oang <= w_sat;
                        DST_OVEL: r_ovel <= w_sat;
                        DST_DISP: r_disp <= w_sat;
                        default:  r_lvel <= w_sat;
                    endcase
                end
                OP_REL:    r_rel <= w_rel;
                OP_EMIT:   r_out <= w_out;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev       <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go && (w_op == OP_UNWRAP)) begin
                r_rev  <= w_rev_next;
                r_prev <= r_d;
            end
            if (w_go && (w_op == OP_EMIT)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_data    = r_out;
    assign o_out_valid   = r_out_valid;
    assign o_st.rem_busy = w_rem_busy;
    assign o_st.out_busy = r_out_valid && i_out_stall;

    `MTE_CHECK_NEXT(a_rev_single_step, i_clk, i_rst_n, w_go && (w_op == OP_UNWRAP), (r_rev == $past(r_rev)) || (r_rev == $past(r_rev) + 32'sd1) || (r_rev == $past(r_rev) - 32'sd1), "turn counter moved by more than one")
    `MTE_CHECK_NEXT(a_rev_only_on_unwrap, i_clk, i_rst_n, !(w_go && (w_op == OP_UNWRAP)), $stable(r_rev), "turn counter changed outside the unwrap step")

endmodule
